FILE: src/hb64_pkg.sv
package hb64_pkg;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [3:0] NIB_HI     = 4'hC;
    localparam logic [3:0] NIB_LO     = 4'h3;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       has;
        logic       last;
    } hb64_res_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [5:0] carry;
        logic [5:0] sx;
        logic       done;
    } hb64_feed_t;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] w;
        logic [7:0] r;
        w = {2'b00, s};
        priority if (s < 6'd26) begin
            r = 8'h41 + w;
        end else if (s < 6'd52) begin
            r = 8'h61 + w - 8'd26;
        end else if (s < 6'd62) begin
            r = 8'h30 + w - 8'd52;
        end else if (s == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

    function automatic hb64_feed_t feed(input logic [1:0] phase, input logic [5:0] carry,
                                        input logic [3:0] n);
        hb64_feed_t f;
        logic [3:0] nh;
        logic [3:0] nl;
        f  = '0;
        nh = n & NIB_HI;
        nl = n & NIB_LO;
        unique case (phase)
            2'd0: begin
                f.carry = {n, 2'b00};
                f.phase = 2'd1;
            end
            2'd1: begin
                f.sx    = carry | {4'd0, nh[3:2]};
                f.carry = {nl[1:0], 4'd0};
                f.phase = 2'd2;
                f.done  = 1'b1;
            end
            default: begin
                f.sx    = carry | {2'b00, n};
                f.carry = 6'd0;
                f.phase = 2'd0;
                f.done  = 1'b1;
            end
        endcase
        return f;
    endfunction

endpackage

FILE: src/hex_to_base64_stream.sv
// Path: a request is held in the input register, and its result, if it yields one, is captured
// in the result register, which drives m_tvalid (input register, result register).
// Throughput: one request per cycle, sustained, when m_tready stays high.
// Each request is handled in a single pass of short logic between the two registers.
// Reset (aresetn low, synchronous) empties both registers and returns to the start state.
module hex_to_base64_stream
    import hb64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // is_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] has_char
    output logic       m_tlast    // last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_has_reg;
    logic       out_last_reg;

    logic       out_free;
    logic       fire;
    hb64_res_t  res;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    hb64_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_char (in_char_reg),
        .is_end  (in_end_reg),
        .res     (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire && res.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (fire && res.valid) begin
            out_char_reg <= res.ch;
            out_has_reg  <= res.has;
            out_last_reg <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("result without character before end");

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("held request dropped");

endmodule

FILE: src/hb64_conv.sv
module hb64_conv
    import hb64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] in_char,
    input  logic       is_end,
    output hb64_res_t  res
);

    logic [1:0] phase_reg, phase_next;
    logic [5:0] carry_reg, carry_next;
    logic       at_start_reg, at_start_next;
    logic       pend_reg, pend_next;

    hb64_feed_t f0, f1;
    logic       do_f0, do_f1;
    logic [1:0] ph_mid;
    logic [5:0] cy_mid;

    always_comb begin
        res           = '0;
        phase_next    = phase_reg;
        carry_next    = carry_reg;
        at_start_next = at_start_reg;
        pend_next     = pend_reg;
        do_f0         = 1'b0;
        do_f1         = 1'b0;

        // held leading zero gets fed as a digit
        f0     = feed(phase_reg, carry_reg, 4'd0);
        ph_mid = phase_reg;
        cy_mid = carry_reg;

        if (is_end) begin
            do_f0 = !at_start_reg && pend_reg;
        end else if (at_start_reg && !pend_reg && in_char == CHAR_MINUS) begin
            pend_next = 1'b1;
            res.valid = 1'b1;
            res.ch    = CHAR_MINUS;
            res.has   = 1'b1;
        end else if (at_start_reg) begin
            at_start_next = 1'b0;
            if (in_char == CHAR_ZERO) begin
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
                do_f1     = 1'b1;
            end
        end else if (pend_reg) begin
            pend_next = 1'b0;
            if (in_char != CHAR_X) begin
                do_f0 = 1'b1;
                do_f1 = 1'b1;
            end
        end else begin
            do_f1 = 1'b1;
        end

        if (do_f0) begin
            ph_mid = f0.phase;
            cy_mid = f0.carry;
        end
        f1 = feed(ph_mid, cy_mid, nibble_of(in_char));

        if (is_end) begin
            res.valid     = 1'b1;
            res.last      = 1'b1;
            res.has       = (ph_mid != 2'd0);
            res.ch        = (ph_mid != 2'd0) ? b64_char(cy_mid) : 8'd0;
            phase_next    = 2'd0;
            carry_next    = 6'd0;
            at_start_next = 1'b1;
            pend_next     = 1'b0;
        end else if (do_f1) begin
            phase_next = f1.phase;
            carry_next = f1.carry;
            if (f1.done) begin
                res.valid = 1'b1;
                res.has   = 1'b1;
                res.ch    = b64_char(f1.sx);
            end else if (do_f0 && f0.done) begin
                res.valid = 1'b1;
                res.has   = 1'b1;
                res.ch    = b64_char(f0.sx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 2'd0;
            carry_reg    <= 6'd0;
            at_start_reg <= 1'b1;
            pend_reg     <= 1'b0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            carry_reg    <= carry_next;
            at_start_reg <= at_start_next;
            pend_reg     <= pend_next;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("phase out of range");

    a_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && is_end |=> at_start_reg && !pend_reg && phase_reg == 2'd0
                           && carry_reg == 6'd0)
        else $error("end request did not restart");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && is_end |-> res.valid && res.last)
        else $error("end request without result");

    a_minus_start: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !is_end && res.valid && res.ch == CHAR_MINUS |-> at_start_reg && !pend_reg)
        else $error("minus echoed outside start");

endmodule

FILE: bench/tb.sv
module tb;
    import hb64_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
    } b64_out_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // predictor state
    logic [1:0] grp_pos;
    logic [5:0] pend_bits;
    logic       at_head;
    logic       head_hold;

    b64_out_t   chars_due[$];
    int         fail_cnt  = 0;
    int         idle_cyc  = 0;
    int         stall_pct = 0;
    int         gap_pct   = 0;
    int         rdy_hold  = 0;
    int         n_sent    = 0;

    hex_to_base64_stream dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            return 4'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            return 4'(c - 8'h37);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] b64_sym(input logic [5:0] s);
        int v;
        v = s;
        if (v <= 25) begin
            return 8'("A" + v);
        end else if (v <= 51) begin
            return 8'("a" + v - 26);
        end else if (v <= 61) begin
            return 8'("0" + v - 52);
        end else if (v == 62) begin
            return "+";
        end
        return "/";
    endfunction

    task automatic clear_model();
        grp_pos   = 2'd0;
        pend_bits = 6'd0;
        at_head   = 1'b1;
        head_hold = 1'b0;
    endtask

    task automatic push_due(input logic [7:0] ch, input logic has, input logic last);
        b64_out_t o;
        o.ch   = ch;
        o.has  = has;
        o.last = last;
        chars_due.push_back(o);
    endtask

    // one nibble into the 12-bit group; got = sextet completed
    task automatic take_nibble(input logic [3:0] n, output logic got, output logic [5:0] sx);
        got = 1'b0;
        sx  = 6'd0;
        case (grp_pos)
            2'd0: begin
                pend_bits = {n, 2'b00};
                grp_pos   = 2'd1;
            end
            2'd1: begin
                sx        = pend_bits | {4'd0, n[3:2]};
                pend_bits = {n[1:0], 4'd0};
                grp_pos   = 2'd2;
                got       = 1'b1;
            end
            default: begin
                sx        = pend_bits | {2'b00, n};
                pend_bits = 6'd0;
                grp_pos   = 2'd0;
                got       = 1'b1;
            end
        endcase
    endtask

    task automatic predict_req(input logic [7:0] c, input logic e);
        logic       got;
        logic [5:0] sx;
        if (e) begin
            if (!at_head && head_hold) begin
                take_nibble(4'd0, got, sx);
            end
            if (grp_pos != 2'd0) begin
                push_due(b64_sym(pend_bits), 1'b1, 1'b1);
            end else begin
                push_due(8'h00, 1'b0, 1'b1);
            end
            clear_model();
            return;
        end
        if (at_head && !head_hold && c == CHAR_MINUS) begin
            head_hold = 1'b1;
            push_due(CHAR_MINUS, 1'b1, 1'b0);
            return;
        end
        if (at_head) begin
            at_head = 1'b0;
            if (c == CHAR_ZERO) begin
                head_hold = 1'b1;
                return;
            end
            head_hold = 1'b0;
        end else if (head_hold) begin
            head_hold = 1'b0;
            if (c == CHAR_X) begin
                return;
            end
            take_nibble(4'd0, got, sx);
        end
        take_nibble(hex_val(c), got, sx);
        if (got) begin
            push_due(b64_sym(sx), 1'b1, 1'b0);
        end
    endtask

    task automatic send_req(input logic [7:0] c, input logic e);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? pick_len() : 0;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= e;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_req(c, e);
        n_sent++;
    endtask

    task automatic send_text(input string t, input logic with_end);
        for (int i = 0; i < t.len(); i++) begin
            send_req(t[i], 1'b0);
        end
        if (with_end) begin
            send_req(8'($urandom), 1'b1);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // mostly well-formed numbers with random content, some noise
    task automatic send_stream();
        string digits;
        int    len;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
                send_req(8'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 1) == 1) begin
                send_req(8'($urandom), 1'b1);
            end
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            send_req(CHAR_MINUS, 1'b0);
        end
        if ($urandom_range(0, 1) == 1) begin
            send_req(CHAR_ZERO, 1'b0);
            send_req(($urandom_range(0, 7) == 0) ? 8'h58 : CHAR_X, 1'b0);
        end
        len = $urandom_range(0, 12);
        repeat (len) begin
            if ($urandom_range(0, 19) == 0) begin
                send_req(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_req(digits[$urandom_range(0, digits.len() - 1)], 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            send_req(8'($urandom), 1'b1);
        end
    endtask

    task automatic test_directed();
        stall_pct = 10;
        gap_pct   = 20;
        send_req(8'hA5, 1'b1);
        send_text("-0xFf9", 1'b1);
        send_text("0", 1'b1);
        send_text("0a-", 1'b1);
        send_text("--", 1'b1);
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h00, 1'b1);
        send_text("0x", 1'b1);
        send_text("7e", 1'b1);
        drain_results();
    endtask

    task automatic test_back_to_back();
        int stop_at;
        stall_pct = 0;
        gap_pct   = 0;
        stop_at   = n_sent + 60;
        while (n_sent < stop_at) begin
            send_stream();
        end
        drain_results();
    endtask

    task automatic test_random_streams();
        int stop_at;
        stop_at = n_sent + 360;
        while (n_sent < stop_at) begin
            stall_pct = $urandom_range(0, 30);
            gap_pct   = $urandom_range(0, 40);
            send_stream();
            if ($urandom_range(0, 9) == 0) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    task automatic test_heavy_stall();
        int stop_at;
        stall_pct = 60;
        gap_pct   = 60;
        stop_at   = n_sent + 60;
        while (n_sent < stop_at) begin
            send_stream();
        end
        send_req(8'h00, 1'b1);
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_hold <= 0;
        end else if (rdy_hold != 0) begin
            m_tready <= 1'b0;
            rdy_hold <= rdy_hold - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_tready <= 1'b0;
            rdy_hold <= pick_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        b64_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (chars_due.size() == 0) begin
                $error("unexpected result: out_char %h has_char %b last %b",
                       m_tdata, m_tuser, m_tlast);
                fail_cnt++;
            end else begin
                want = chars_due.pop_front();
                if (m_tdata !== want.ch) begin
                    $error("out_char: expected %h, got %h", want.ch, m_tdata);
                    fail_cnt++;
                end
                if (m_tuser !== want.has) begin
                    $error("has_char: expected %b, got %b", want.has, m_tuser);
                    fail_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cyc <= 0;
            end else if (idle_cyc >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cyc <= idle_cyc + 1;
            end
        end
    end

    initial begin
        clear_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_to_back();
        test_random_streams();
        test_heavy_stall();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && chars_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: hex_to_base64_stream.f
src/hb64_pkg.sv
src/hb64_conv.sv
src/hex_to_base64_stream.sv
bench/tb.sv
